/* src/pmr_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register indexes and result codes of the smoothness router.
package pmr_pkg;

  // Default width of the prime value.
  localparam int DEFAULT_WIDTH = 32;

  // Configuration register layout.
  localparam int LIMIT_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE_LIMIT  = 2'd2;

  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST   = 10'd100;
  localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 10'd10;
  localparam logic [LIMIT_W-1:0] ROUTE_LIMIT_RST  = 10'd20;

  // Result field widths.
  localparam int MINUS_W = 32;
  localparam int PLUS_W  = 33;
  localparam int CLASS_W = 2;
  localparam int ROUTE_W = 2;

  // Smoothness classes.
  localparam logic [CLASS_W-1:0] CLASS_HIGH   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_LOW    = 2'd2;

  // Bit positions within the route hint.
  localparam int ROUTE_MINUS_BIT = 0;
  localparam int ROUTE_PLUS_BIT  = 1;

endpackage

/* src/pmr_div.sv */
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per clock cycle.
module pmr_div #(
  parameter int W = pmr_pkg::DEFAULT_WIDTH + 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  import pmr_pkg::*;

  localparam int CNT_W = $clog2(W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  // One restoring step: shift in the next dividend bit and try a subtraction.
  assign shifted = {acc_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(W);
      acc_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      if (!diff[W]) begin
        acc_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        acc_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Data path registers carry no reset.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = acc_r;

endmodule

/* src/pm1_pp1_smoothness_router_core.sv */
`timescale 1ns / 1ps
// Top level of the smoothness router: sequencer, limit registers and result registers.
//
// A transaction presents a prime p on in_prime_value with start while busy is low. The block
// finds the largest prime factor of p-1 and then of p+1 by trial division, using one shared
// divider that delivers a quotient bit per cycle for each candidate divisor. The number of
// candidates per side is about half the square root of the value being factored, falling as
// small factors are divided out, plus one more division for each repeated factor. Each side
// then rates its factor with three limit multiplications, each followed by a compare. The
// result appears for exactly one cycle with out_valid, when busy is already low again; the
// receiver cannot stall it. Limits are to be written by the user on the cfg port only while
// busy is low; the block itself does not enforce this.
module pm1_pp1_smoothness_router_core #(
  parameter int WIDTH = pmr_pkg::DEFAULT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [WIDTH-1:0]                  in_prime_value,
  input  logic                              cfg_wr_en,
  input  logic [pmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmr_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                              out_valid,
  output logic [pmr_pkg::MINUS_W-1:0]       out_minus_largest,
  output logic [pmr_pkg::PLUS_W-1:0]        out_plus_largest,
  output logic [pmr_pkg::CLASS_W-1:0]       out_minus_class,
  output logic [pmr_pkg::CLASS_W-1:0]       out_plus_class,
  output logic [pmr_pkg::ROUTE_W-1:0]       out_route
);
  import pmr_pkg::*;

  // Factoring works one bit wider than p so that p+1 always fits.
  localparam int W1     = WIDTH + 1;
  localparam int PROD_W = W1 + LIMIT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_WAIT  = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_CMP   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic                side_r, side_nxt;          // low for p-1, high for p+1
  logic [CFG_IDX_W-1:0] lim_sel_r, lim_sel_nxt;
  logic                hi_lt_r, hi_lt_nxt;
  logic                md_lt_r, md_lt_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [WIDTH-1:0]    p_r, p_nxt;
  logic [W1-1:0]       rem_r, rem_nxt;
  logic [W1-1:0]       best_r, best_nxt;
  logic [W1-1:0]       q_r, q_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;

  logic [W1-1:0]       m_large_r, m_large_nxt;
  logic [W1-1:0]       p_large_r, p_large_nxt;
  logic [CLASS_W-1:0]  m_class_r, m_class_nxt;
  logic [CLASS_W-1:0]  p_class_r, p_class_nxt;
  logic                m_good_r, m_good_nxt;
  logic                p_good_r, p_good_nxt;

  logic [LIMIT_W-1:0]  high_limit_r, medium_limit_r, route_limit_r;
  logic [LIMIT_W-1:0]  lim_mux;

  logic                div_start;
  logic                div_done;
  logic [W1-1:0]       div_quo;
  logic [W1-1:0]       div_rem;

  // Shared divider for every trial division.
  pmr_div #(
    .W (W1)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_r),
    .divisor   (q_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Limit registers; writes to the spare index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_limit_r   <= HIGH_LIMIT_RST;
      medium_limit_r <= MEDIUM_LIMIT_RST;
      route_limit_r  <= ROUTE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HIGH_LIMIT:   high_limit_r   <= cfg_data;
        REG_MEDIUM_LIMIT: medium_limit_r <= cfg_data;
        REG_ROUTE_LIMIT:  route_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Limit that the multiplier sees in this step.
  always_comb begin
    case (lim_sel_r)
      REG_HIGH_LIMIT:   lim_mux = high_limit_r;
      REG_MEDIUM_LIMIT: lim_mux = medium_limit_r;
      default:          lim_mux = route_limit_r;
    endcase
  end

  assign div_start = (state_r == ST_DIV);

  // Sequencer: set up a side, trial-divide, then rate the factor against the three limits.
  always_comb begin
    logic                side_fin;
    logic [W1-1:0]       fin_large;
    logic [CLASS_W-1:0]  fin_class;
    logic                fin_good;
    logic                lt;

    state_nxt     = state_r;
    side_nxt      = side_r;
    lim_sel_nxt   = lim_sel_r;
    hi_lt_nxt     = hi_lt_r;
    md_lt_nxt     = md_lt_r;
    out_valid_nxt = 1'b0;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    best_nxt      = best_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    m_large_nxt   = m_large_r;
    p_large_nxt   = p_large_r;
    m_class_nxt   = m_class_r;
    p_class_nxt   = p_class_r;
    m_good_nxt    = m_good_r;
    p_good_nxt    = p_good_r;

    side_fin  = 1'b0;
    fin_large = '0;
    fin_class = CLASS_LOW;
    fin_good  = 1'b0;
    lt        = (prod_r < PROD_W'(p_r));

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          p_nxt     = in_prime_value;
          side_nxt  = 1'b0;
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        // The p-1 side closes at once as low and not good for p up to 2, the p+1 side for p up to 1.
        if ((!side_r && (p_r <= WIDTH'(2))) || (side_r && (p_r <= WIDTH'(1)))) begin
          side_fin = 1'b1;
        end else begin
          rem_nxt     = side_r ? (W1'(p_r) + W1'(1)) : (W1'(p_r) - W1'(1));
          best_nxt    = W1'(1);
          q_nxt       = W1'(2);
          state_nxt   = ST_DIV;
        end
      end

      ST_DIV: begin
        state_nxt = ST_WAIT;
      end

      ST_WAIT: begin
        if (div_done) begin
          if (q_r > div_quo) begin
            // Candidate passed the square root: whatever is left is prime or one.
            if (rem_r > W1'(1)) begin
              best_nxt = rem_r;
            end
            lim_sel_nxt = REG_HIGH_LIMIT;
            state_nxt   = ST_MUL;
          end else if (div_rem == '0) begin
            // Divide the factor out and try the same candidate again.
            best_nxt  = q_r;
            rem_nxt   = div_quo;
            state_nxt = ST_DIV;
          end else begin
            q_nxt     = (q_r == W1'(2)) ? W1'(3) : (q_r + W1'(2));
            state_nxt = ST_DIV;
          end
        end
      end

      ST_MUL: begin
        prod_nxt  = PROD_W'(best_r) * PROD_W'(lim_mux);
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        case (lim_sel_r)
          REG_HIGH_LIMIT: begin
            hi_lt_nxt   = lt;
            lim_sel_nxt = REG_MEDIUM_LIMIT;
            state_nxt   = ST_MUL;
          end
          REG_MEDIUM_LIMIT: begin
            md_lt_nxt   = lt;
            lim_sel_nxt = REG_ROUTE_LIMIT;
            state_nxt   = ST_MUL;
          end
          default: begin
            side_fin  = 1'b1;
            fin_large = best_r;
            fin_class = hi_lt_r ? CLASS_HIGH : (md_lt_r ? CLASS_MEDIUM : CLASS_LOW);
            fin_good  = lt;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Store the finished side and move on to the next one or to the result.
    if (side_fin) begin
      if (!side_r) begin
        m_large_nxt = fin_large;
        m_class_nxt = fin_class;
        m_good_nxt  = fin_good;
        side_nxt    = 1'b1;
        state_nxt   = ST_SETUP;
      end else begin
        p_large_nxt   = fin_large;
        p_class_nxt   = fin_class;
        p_good_nxt    = fin_good;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= 1'b0;
      lim_sel_r   <= REG_HIGH_LIMIT;
      hi_lt_r     <= 1'b0;
      md_lt_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      lim_sel_r   <= lim_sel_nxt;
      hi_lt_r     <= hi_lt_nxt;
      md_lt_r     <= md_lt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Data path and result registers carry no reset.
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    rem_r     <= rem_nxt;
    best_r    <= best_nxt;
    q_r       <= q_nxt;
    prod_r    <= prod_nxt;
    m_large_r <= m_large_nxt;
    p_large_r <= p_large_nxt;
    m_class_r <= m_class_nxt;
    p_class_r <= p_class_nxt;
    m_good_r  <= m_good_nxt;
    p_good_r  <= p_good_nxt;
  end

  // Result ports hold steady until the next transaction finishes its first side.
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_minus_largest = MINUS_W'(m_large_r);
  assign out_plus_largest  = PLUS_W'(p_large_r);
  assign out_minus_class   = m_class_r;
  assign out_plus_class    = p_class_r;
  assign out_route         = {p_good_r, m_good_r};

endmodule

/* src/pmr_chk.sv */
`timescale 1ns / 1ps
// Port-level assertions for the smoothness router and the bind that attaches them.
module pmr_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [pmr_pkg::MINUS_W-1:0]   out_minus_largest,
  input logic [pmr_pkg::CLASS_W-1:0]   out_minus_class,
  input logic [pmr_pkg::CLASS_W-1:0]   out_plus_class,
  input logic [pmr_pkg::ROUTE_W-1:0]   out_route
);
  import pmr_pkg::*;

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // A result is a single-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // The result appears once the block has gone idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // Both classes carry a defined code.
  a_class_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minus_class == CLASS_HIGH || out_minus_class == CLASS_MEDIUM ||
                   out_minus_class == CLASS_LOW) &&
                  (out_plus_class == CLASS_HIGH || out_plus_class == CLASS_MEDIUM ||
                   out_plus_class == CLASS_LOW))
    else $error("undefined smoothness class");

  // With no p-1 factor the p-1 side is low and never routed.
  a_minus_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_minus_largest == '0) |->
      (out_minus_class == CLASS_LOW) && !out_route[ROUTE_MINUS_BIT])
    else $error("empty p-1 side was rated or routed");

endmodule

bind pm1_pp1_smoothness_router_core pmr_chk u_pmr_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_minus_largest (out_minus_largest),
  .out_minus_class   (out_minus_class),
  .out_plus_class    (out_plus_class),
  .out_route         (out_route)
);

/* sim/pm1_pp1_smoothness_router_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the smoothness router core with its own result predictor.
module pm1_pp1_smoothness_router_core_tb;
  import pmr_pkg::*;

  localparam int VALUE_W        = DEFAULT_WIDTH;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 20_000_000;

  typedef struct {
    logic [MINUS_W-1:0] minus_largest;
    logic [PLUS_W-1:0]  plus_largest;
    logic [CLASS_W-1:0] minus_class;
    logic [CLASS_W-1:0] plus_class;
    logic [ROUTE_W-1:0] route;
  } smooth_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [VALUE_W-1:0]   in_prime_value;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_data;
  logic                 out_valid;
  logic [MINUS_W-1:0]   out_minus_largest;
  logic [PLUS_W-1:0]    out_plus_largest;
  logic [CLASS_W-1:0]   out_minus_class;
  logic [CLASS_W-1:0]   out_plus_class;
  logic [ROUTE_W-1:0]   out_route;

  // Predictor copy of the limit registers.
  logic [LIMIT_W-1:0] high_lim   = HIGH_LIMIT_RST;
  logic [LIMIT_W-1:0] medium_lim = MEDIUM_LIMIT_RST;
  logic [LIMIT_W-1:0] route_lim  = ROUTE_LIMIT_RST;

  smooth_result_t pending_results[$];
  int unsigned    error_count  = 0;
  int unsigned    quiet_cycles = 0;
  bit             sender_idles = 1'b1;

  pm1_pp1_smoothness_router_core #(.WIDTH(VALUE_W)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_prime_value    (in_prime_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_minus_largest (out_minus_largest),
    .out_plus_largest  (out_plus_largest),
    .out_minus_class   (out_minus_class),
    .out_plus_class    (out_plus_class),
    .out_route         (out_route)
  );

  // Free-running clock, 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Largest prime factor by trial division over 2 and the odd numbers.
  function automatic longint unsigned largest_prime_factor(input longint unsigned n);
    longint unsigned rest;
    longint unsigned best;
    longint unsigned d;
    rest = n;
    best = 1;
    d    = 2;
    while (d <= rest / d) begin
      if (rest % d == 0) begin
        best = d;
        while (rest % d == 0) rest = rest / d;
      end
      d = d + ((d == 2) ? 1 : 2);
    end
    if (rest > 1) best = rest;
    return best;
  endfunction

  // Exact form of factor * limit < p; a zero limit passes any non-zero p.
  function automatic bit under_limit(input longint unsigned factor, input logic [LIMIT_W-1:0] limit,
                                     input longint unsigned p);
    longint unsigned lim;
    lim = 64'(limit);
    if (lim == 0) return p > 0;
    return factor <= (p - 1) / lim;
  endfunction

  function automatic logic [CLASS_W-1:0] smoothness_class(input longint unsigned factor,
                                                          input longint unsigned p);
    if (under_limit(factor, high_lim, p)) return CLASS_HIGH;
    if (under_limit(factor, medium_lim, p)) return CLASS_MEDIUM;
    return CLASS_LOW;
  endfunction

  // Expected result for one value under the current limits.
  function automatic smooth_result_t predict_smoothness(input logic [VALUE_W-1:0] value);
    smooth_result_t  r;
    longint unsigned p;
    longint unsigned fac;
    p               = 64'(value);
    r.minus_largest = '0;
    r.plus_largest  = '0;
    r.minus_class   = CLASS_LOW;
    r.plus_class    = CLASS_LOW;
    r.route         = '0;
    if (p > 2) begin
      fac                      = largest_prime_factor(p - 1);
      r.minus_largest          = fac[MINUS_W-1:0];
      r.minus_class            = smoothness_class(fac, p);
      r.route[ROUTE_MINUS_BIT] = under_limit(fac, route_lim, p);
    end
    if (p > 1) begin
      fac                     = largest_prime_factor(p + 1);
      r.plus_largest          = fac[PLUS_W-1:0];
      r.plus_class            = smoothness_class(fac, p);
      r.route[ROUTE_PLUS_BIT] = under_limit(fac, route_lim, p);
    end
    return r;
  endfunction

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    smooth_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: minus_largest %0d plus_largest %0d",
               out_minus_largest, out_plus_largest);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_minus_largest !== exp_r.minus_largest) begin
          $error("minus_largest: expected %0d, got %0d", exp_r.minus_largest, out_minus_largest);
          error_count++;
        end
        if (out_plus_largest !== exp_r.plus_largest) begin
          $error("plus_largest: expected %0d, got %0d", exp_r.plus_largest, out_plus_largest);
          error_count++;
        end
        if (out_minus_class !== exp_r.minus_class) begin
          $error("minus_class: expected %0d, got %0d", exp_r.minus_class, out_minus_class);
          error_count++;
        end
        if (out_plus_class !== exp_r.plus_class) begin
          $error("plus_class: expected %0d, got %0d", exp_r.plus_class, out_plus_class);
          error_count++;
        end
        if (out_route !== exp_r.route) begin
          $error("route: expected %0d, got %0d", exp_r.route, out_route);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL pm1_pp1_smoothness_router_core");
      $finish;
    end
  end

  // Offer one value, optionally after an idle burst, and record its expected result.
  // Start is left high so that a following transaction can go back to back.
  task automatic send_prime(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    if (sender_idles && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_prime_value <= value;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_smoothness(value));
  endtask

  // Hold off the sender until every expected result has come and the block is idle.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three limits; only called while the block is idle.
  task automatic program_limits(input logic [LIMIT_W-1:0] hi, input logic [LIMIT_W-1:0] med,
                                input logic [LIMIT_W-1:0] rt);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_HIGH_LIMIT;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_MEDIUM_LIMIT;
    cfg_data  <= med;
    @(posedge clk);
    cfg_index <= REG_ROUTE_LIMIT;
    cfg_data  <= rt;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    high_lim   = hi;
    medium_lim = med;
    route_lim  = rt;
  endtask

  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return LIMIT_W'(1);
      3, 4, 5: return LIMIT_W'($urandom_range(2, 64));
      default: return LIMIT_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Mostly small values so that trial division stays short; a few full-width ones.
  function automatic logic [VALUE_W-1:0] random_prime_value();
    logic [VALUE_W-1:0] base;
    case ($urandom_range(0, 39))
      0:       return $urandom;
      1, 2, 3: return $urandom & 32'h00FF_FFFF;
      4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
        // Neighbour of a smooth number, so that one side can reach the high class.
        base = $urandom_range(1, 255) << $urandom_range(0, 16);
        return ($urandom_range(0, 1) == 0) ? base + 1 : base - 1;
      end
      14, 15, 16, 17, 18, 19, 20, 21, 22, 23: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // Small-value special cases and each class under the reset limits.
  task automatic test_reset_limits();
    logic [VALUE_W-1:0] vals[] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7,
                                   32'd101, 32'd65537, 32'd1000000, 32'hFFFF_0001,
                                   32'hFFFF_FFFF};
    foreach (vals[i]) send_prime(vals[i]);
  endtask

  // Limits at zero, at full scale, at one and mixed.
  task automatic test_limit_extremes();
    logic [VALUE_W-1:0] vals[] = '{32'd1, 32'd2, 32'd3, 32'd97, 32'd65537};
    wait_for_results();
    program_limits('0, '0, '0);
    foreach (vals[i]) send_prime(vals[i]);
    send_prime(32'hFFFF_FFFF);
    wait_for_results();
    program_limits('1, '1, '1);
    foreach (vals[i]) send_prime(vals[i]);
    wait_for_results();
    program_limits(10'd1, 10'd1, 10'd1);
    send_prime(32'd3);
    send_prime(32'd65537);
    wait_for_results();
    program_limits('1, 10'd1, '0);
    send_prime(32'd101);
    send_prime(32'd65537);
  endtask

  // Random values in phases with random limits; the last phase runs without idling.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      wait_for_results();
      program_limits(random_limit(), random_limit(), random_limit());
      sender_idles = (phase < 4);
      repeat (15) send_prime(random_prime_value());
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_prime_value <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_HIGH_LIMIT;
    cfg_data       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limits();
    test_limit_extremes();
    test_random_traffic();
    wait_for_results();
    if (error_count == 0) begin
      $display("PASS pm1_pp1_smoothness_router_core");
    end else begin
      $display("FAIL pm1_pp1_smoothness_router_core");
    end
    $finish;
  end

endmodule
